// ===== rtl/ascfd_pkg.sv =====
// Shared types and constants for the ADC status/channel frame deframer.
// Holds word kinds, field widths and the byte-position encoding.
// No dependencies.
package ascfd_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 24;
    localparam int PARTIAL_W  = 16;
    localparam int CHAN_W     = 3;
    localparam int POS_W      = 6;
    localparam int USER_W     = 5;

    // Bytes per 24-bit word, and the phase of the last byte of a word
    localparam int BYTES_PER_WORD = 3;
    localparam logic [1:0] PHASE_LAST = 2'd2;

    // Frame position value meaning "idle", loaded at reset until the next frame start
    localparam logic [POS_W-1:0] POS_IDLE = '1;

    // Word kinds
    typedef enum logic {
        KIND_STATUS  = 1'b0,
        KIND_CHANNEL = 1'b1
    } word_kind_t;

    // Result payload
    typedef struct packed {
        logic [CHAN_W-1:0] channel_index;
        logic              device_index;
        word_kind_t        word_kind;
    } word_tag_t;

endpackage

// ===== rtl/adc_status_channel_frame_deframer.sv =====
// Top level of the ADC status/channel frame deframer.
// Assembles converter data bytes into tagged 24-bit words.
// Depends on ascfd_pkg.
//
// Usage:
//   Input stream (s_*): one converter byte per transaction in s_tdata; s_tuser
//   flags the first byte of a frame and restarts framing at that byte.
//   Each frame holds per device one 3-byte status word and then
//   CHANNELS_PER_DEVICE 3-byte samples, MSB first; a second device follows
//   when daisy_enable is set. Bytes past the end of a frame are dropped.
//   Output stream (m_*): one transaction per completed word; m_tdata is the
//   raw word, m_tuser tags kind/device/channel, m_tlast marks the frame's
//   last word.
//   Output: a word is registered and appears on m_* in the cycle after its third byte is taken.
//   Throughput: one byte per cycle while s_tready is high; the byte counter and shift register are
//   updated together and feed one output register.
//   Stall: while the output register holds an untaken word, s_tready follows
//   m_tready; bytes that complete no word still pass when the output is free.
//   Reset: output empty, framing idle until the next frame start, daisy off.
//   cfg_we/cfg_wdata write daisy_enable; write only while the block is idle.
module adc_status_channel_frame_deframer #(
    parameter int CHANNELS_PER_DEVICE = 8,
    parameter int MAX_DEVICES         = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,    // daisy_enable
    // byte input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ascfd_pkg::BYTE_W-1:0]  s_tdata,      // [7:0] rx_byte
    input  logic                          s_tuser,      // [0] frame_start
    // word output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ascfd_pkg::WORD_W-1:0]  m_tdata,      // [23:0] word_value
    output logic [ascfd_pkg::USER_W-1:0]  m_tuser,      // [0] word_kind,
                                                        // [1] device_index,
                                                        // [4:2] channel_index
    output logic                          m_tlast       // frame_last
);
    import ascfd_pkg::*;

    localparam int SLOTS   = CHANNELS_PER_DEVICE + 1;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LEN_ONE = SLOTS * BYTES_PER_WORD;
    localparam int LEN_TWO = ((MAX_DEVICES >= 2) ? 2 : 1) * LEN_ONE;

    // Configuration
    logic daisy_reg;

    // Framing state
    logic [POS_W-1:0]     pos_reg,     pos_next;
    logic [1:0]           phase_reg,   phase_next;
    logic [SLOT_W-1:0]    slot_reg,    slot_next;
    logic                 dev_reg,     dev_next;
    logic [PARTIAL_W-1:0] partial_reg, partial_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg,  out_word_next;
    word_tag_t         out_tag_reg,   out_tag_next;
    logic              out_last_reg,  out_last_next;

    logic              in_fire;
    logic [POS_W-1:0]  frame_len;
    logic [POS_W-1:0]  cur_pos;
    logic [1:0]        cur_phase;
    logic [SLOT_W-1:0] cur_slot;
    logic              cur_dev;
    logic [PARTIAL_W-1:0] cur_partial;
    logic [SLOT_W-1:0] slot_minus;
    logic              emit;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Frame length follows the current daisy setting
    assign frame_len = daisy_reg ? POS_W'(LEN_TWO) : POS_W'(LEN_ONE);

    // Framing step: one byte per transaction
    always_comb begin
        // frame start restarts counting at this byte
        if (s_tuser) begin
            cur_pos     = '0;
            cur_phase   = '0;
            cur_slot    = '0;
            cur_dev     = 1'b0;
            cur_partial = '0;
        end else begin
            cur_pos     = pos_reg;
            cur_phase   = phase_reg;
            cur_slot    = slot_reg;
            cur_dev     = dev_reg;
            cur_partial = partial_reg;
        end

        slot_minus = cur_slot - SLOT_W'(1);

        pos_next     = pos_reg;
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        dev_next     = dev_reg;
        partial_next = partial_reg;
        emit         = 1'b0;

        out_word_next = out_word_reg;
        out_tag_next  = out_tag_reg;
        out_last_next = out_last_reg;

        if (in_fire) begin
            pos_next     = cur_pos;
            phase_next   = cur_phase;
            slot_next    = cur_slot;
            dev_next     = cur_dev;
            partial_next = cur_partial;
            if (cur_pos < frame_len) begin
                pos_next = cur_pos + POS_W'(1);
                if (cur_phase != PHASE_LAST) begin
                    // gather a leading byte
                    partial_next = {cur_partial[PARTIAL_W-BYTE_W-1:0], s_tdata};
                    phase_next   = cur_phase + 2'd1;
                end else begin
                    // word complete
                    emit          = 1'b1;
                    partial_next  = '0;
                    phase_next    = '0;
                    out_word_next = {cur_partial, s_tdata};
                    out_last_next = (cur_pos + POS_W'(1)) == frame_len;
                    if (cur_slot == '0) begin
                        out_tag_next.word_kind     = KIND_STATUS;
                        out_tag_next.channel_index = '0;
                    end else begin
                        out_tag_next.word_kind     = KIND_CHANNEL;
                        out_tag_next.channel_index = CHAN_W'(slot_minus);
                    end
                    out_tag_next.device_index = cur_dev;
                    if (cur_slot == SLOT_W'(SLOTS - 1)) begin
                        slot_next = '0;
                        dev_next  = 1'b1;
                    end else begin
                        slot_next = cur_slot + SLOT_W'(1);
                    end
                end
            end
        end
    end

    // Output valid: load on emit, clear when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            daisy_reg     <= 1'b0;
            pos_reg       <= POS_IDLE;
            phase_reg     <= '0;
            slot_reg      <= '0;
            dev_reg       <= 1'b0;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                daisy_reg <= cfg_wdata;
            end
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            dev_reg       <= dev_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
        out_tag_reg  <= out_tag_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_tag_reg;
    assign m_tlast  = out_last_reg;

endmodule
